// ===== hdl/ddo_pkg.sv =====
package ddo_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_MAX   = 24;
  localparam int CORDIC_N     = (CORDIC_STEPS > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STEPS;
  // Shifted-modulus subtraction steps: 2*pi << 13 already exceeds 2^31.
  localparam int MOD_STEPS    = 14;
  localparam int STEP_W       = 5;

  localparam logic signed [20:0] PI_Q16      = 21'sd205887;
  localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;
  localparam logic signed [20:0] TWO_PI_Q16  = 21'sd411774;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    REG_LEFT_DPC   = 3'd0,
    REG_RIGHT_DPC  = 3'd1,
    REG_INV_WB     = 3'd2,
    REG_DR_MODE    = 3'd3,
    REG_GYRO_BIAS  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0]        left_dpc;
    logic [31:0]        right_dpc;
    logic [31:0]        inv_wheelbase;
    logic               dr_mode;
    logic signed [15:0] gyro_bias;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_WHEEL, OP_MEAN, OP_HMUL, OP_HACC, OP_ABS,
    OP_MOD, OP_FOLD, OP_ROT, OP_XMUL, OP_YMUL, OP_XYACC, OP_SHOW
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    step_t  step;
  } dp_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_WHEEL, S_MEAN, S_HMUL, S_HACC, S_ABS, S_MOD, S_FOLD,
    S_ROT, S_XMUL, S_YMUL, S_XYACC, S_SHOW
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [31:0] atan_q30(input step_t i);
    unique case (i)
      5'd0:  return 32'sd843314857;
      5'd1:  return 32'sd497837829;
      5'd2:  return 32'sd263043837;
      5'd3:  return 32'sd133525159;
      5'd4:  return 32'sd67021687;
      5'd5:  return 32'sd33543516;
      5'd6:  return 32'sd16775851;
      5'd7:  return 32'sd8388437;
      5'd8:  return 32'sd4194283;
      5'd9:  return 32'sd2097149;
      5'd10: return 32'sd1048576;
      5'd11: return 32'sd524288;
      5'd12: return 32'sd262144;
      5'd13: return 32'sd131072;
      5'd14: return 32'sd65536;
      5'd15: return 32'sd32768;
      5'd16: return 32'sd16384;
      5'd17: return 32'sd8192;
      5'd18: return 32'sd4096;
      5'd19: return 32'sd2048;
      5'd20: return 32'sd1024;
      5'd21: return 32'sd512;
      5'd22: return 32'sd256;
      5'd23: return 32'sd128;
      default: return 32'sd0;
    endcase
  endfunction

endpackage

// ===== hdl/ddo_ctrl.sv =====
module ddo_ctrl
  import ddo_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  state_t state, state_next;
  step_t  step, step_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    step_next      = step;
    out_valid_next = out_valid & out_stall;
    cmd.op         = OP_NONE;
    cmd.step       = step;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_WHEEL;
        end
      end
      S_WHEEL: begin
        cmd.op     = OP_WHEEL;
        state_next = S_MEAN;
      end
      S_MEAN: begin
        cmd.op     = OP_MEAN;
        state_next = S_HMUL;
      end
      S_HMUL: begin
        cmd.op     = OP_HMUL;
        state_next = S_HACC;
      end
      S_HACC: begin
        cmd.op     = OP_HACC;
        state_next = S_ABS;
      end
      S_ABS: begin
        cmd.op     = OP_ABS;
        step_next  = '0;
        state_next = S_MOD;
      end
      S_MOD: begin
        cmd.op = OP_MOD;
        if (step == step_t'(MOD_STEPS - 1)) begin
          step_next  = '0;
          state_next = S_FOLD;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_FOLD: begin
        cmd.op     = OP_FOLD;
        step_next  = '0;
        state_next = S_ROT;
      end
      S_ROT: begin
        cmd.op = OP_ROT;
        if (step == step_t'(CORDIC_N - 1)) begin
          step_next  = '0;
          state_next = S_XMUL;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_XMUL: begin
        cmd.op     = OP_XMUL;
        state_next = S_YMUL;
      end
      S_YMUL: begin
        cmd.op     = OP_YMUL;
        state_next = S_XYACC;
      end
      S_XYACC: begin
        cmd.op     = OP_XYACC;
        state_next = S_SHOW;
      end
      S_SHOW: begin
        if (!out_valid || !out_stall) begin
          cmd.op         = OP_SHOW;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hdl/ddo_dpath.sv =====
module ddo_dpath
  import ddo_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  cfg_t               cfg,
  input  logic signed [15:0] left_count,
  input  logic signed [15:0] right_count,
  input  logic signed [15:0] gyro_rate,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] heading
);

  logic [15:0]        last_left, last_right;
  logic signed [31:0] acc_x, acc_y, acc_heading;

  logic signed [15:0] dl, dr;
  logic signed [16:0] g;
  logic signed [48:0] pl, pr;
  logic signed [31:0] mean, diff;
  logic signed [47:0] dth;
  logic               neg, flip;
  logic [31:0]        rem;
  logic signed [35:0] z;
  logic signed [33:0] x, y;
  logic signed [35:0] px, py;

  logic signed [48:0] wheel_sum, wheel_dif;
  logic signed [63:0] hprod, hsum;
  logic [32:0]        msub;
  logic [STEP_W-1:0]  mshift;
  logic signed [20:0] r0, r1, r2;
  logic               fl;
  logic signed [33:0] xs, ys, cx, sy;
  logic signed [35:0] at;
  logic signed [65:0] mprod;

  always_comb begin
    wheel_sum = pl + pr;
    wheel_dif = pr - pl;
    hprod     = 64'(diff) * 64'($signed({1'b0, cfg.inv_wheelbase}));
    if (cfg.dr_mode) begin
      hsum = 64'(acc_heading) + (64'(g) <<< 16);
    end else begin
      hsum = 64'(acc_heading) + 64'(dth);
    end
    mshift = step_t'(MOD_STEPS - 1) - cmd.step;
    msub   = 33'(TWO_PI_Q16) << mshift;
    // floor modulo into [0, 2pi), then into (-pi, pi], then fold to +-pi/2
    r0 = (neg && rem != 32'd0) ? (TWO_PI_Q16 - $signed({1'b0, rem[19:0]}))
                               : $signed({1'b0, rem[19:0]});
    r1 = (r0 > PI_Q16) ? (r0 - TWO_PI_Q16) : r0;
    fl = 1'b0;
    r2 = r1;
    if (r1 > HALF_PI_Q16) begin
      r2 = r1 - PI_Q16;
      fl = 1'b1;
    end else if (r1 < -HALF_PI_Q16) begin
      r2 = r1 + PI_Q16;
      fl = 1'b1;
    end
    xs = x >>> cmd.step;
    ys = y >>> cmd.step;
    at = 36'(atan_q30(cmd.step));
    cx = flip ? -x : x;
    sy = flip ? -y : y;
    mprod = 66'(mean) * 66'((cmd.op == OP_XMUL) ? cx : sy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_left   <= '0;
      last_right  <= '0;
      acc_x       <= '0;
      acc_y       <= '0;
      acc_heading <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          dl         <= $signed(left_count - last_left);
          dr         <= $signed(right_count - last_right);
          g          <= 17'(gyro_rate) - 17'(cfg.gyro_bias);
          last_left  <= left_count;
          last_right <= right_count;
        end
        OP_WHEEL: begin
          pl <= 49'(dl) * 49'($signed({1'b0, cfg.left_dpc}));
          pr <= 49'(dr) * 49'($signed({1'b0, cfg.right_dpc}));
        end
        OP_MEAN: begin
          mean <= 32'(wheel_sum >>> 17);
          diff <= sat32(64'(wheel_dif >>> 16));
        end
        OP_HMUL:  dth <= 48'(hprod >>> 16);
        OP_HACC:  acc_heading <= sat32(hsum);
        OP_ABS: begin
          neg <= acc_heading[31];
          rem <= acc_heading[31] ? 32'(-acc_heading) : 32'(acc_heading);
        end
        OP_MOD: begin
          if ({1'b0, rem} >= msub) begin
            rem <= 32'({1'b0, rem} - msub);
          end
        end
        OP_FOLD: begin
          z    <= 36'(r2) <<< 14;
          flip <= fl;
          x    <= GAIN_Q30;
          y    <= '0;
        end
        OP_ROT: begin
          if (!z[35]) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - at;
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + at;
          end
        end
        OP_XMUL: px <= 36'(mprod >>> 30);
        OP_YMUL: py <= 36'(mprod >>> 30);
        OP_XYACC: begin
          acc_x <= sat32(64'(acc_x) + 64'(px));
          acc_y <= sat32(64'(acc_y) + 64'(py));
        end
        OP_SHOW: begin
          pos_x   <= acc_x;
          pos_y   <= acc_y;
          heading <= acc_heading;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/differential_drive_odometry.sv =====
// Differential-drive wheel odometry in Q16.16 fixed point.
// Input channel (in_valid / in_stall): one word carries absolute left and
// right encoder counts and a raw gyro z sample. A word is taken on a rising
// edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall): one word per input word with the
// new pose pos_x, pos_y and heading. The pose sits in an output register, so
// the next input word is taken while a finished pose still waits.
// Configuration channel (cfg_valid / cfg_ready): cfg_index picks the register
// (travel per count left/right, inverse wheelbase, gyro mode, gyro bias);
// cfg_ready is always high. Write it only while the block is idle.
// From input accept to out_valid the sequencer runs wheel scaling, the
// heading multiply and the heading accumulate, an absolute value and 14
// shifted subtracts for the modulo-2pi reduction (one shifted subtract a
// cycle), a fold, 16 CORDIC rotations on one shared shift-add unit, x and y
// on one shared multiplier, the accumulate and the output load. It handles
// one word at a time and takes no new word before it is back in idle. While
// the receiver stalls, the finished pose waits in the last state and no new
// word is taken until it moves into the output register.
// Reset (rst, synchronous) zeroes the pose accumulators, previous counts,
// config and sequencer; other datapath registers and pose outputs are not.
module differential_drive_odometry
  import ddo_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] left_count,
  input  logic signed [15:0] right_count,
  input  logic signed [15:0] gyro_rate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] heading,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t    cfg;
  dp_cmd_t cmd;

  // Config registers never back-pressure.
  assign cfg_ready = 1'b1;

  // Store the addressed register; drop writes to unknown indices.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LEFT_DPC:  cfg.left_dpc      <= cfg_data;
        REG_RIGHT_DPC: cfg.right_dpc     <= cfg_data;
        REG_INV_WB:    cfg.inv_wheelbase <= cfg_data;
        REG_DR_MODE:   cfg.dr_mode       <= cfg_data[0];
        REG_GYRO_BIAS: cfg.gyro_bias     <= $signed(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

  // Sequencer: steps the datapath through one word.
  ddo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Datapath: multipliers, reduction, CORDIC and saturating accumulators.
  ddo_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg         (cfg),
    .left_count  (left_count),
    .right_count (right_count),
    .gyro_rate   (gyro_rate),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .heading     (heading)
  );

endmodule

// ===== tb/sv/differential_drive_odometry_tb.sv =====
// Odometry block testbench: drives encoder/gyro words with bursty timing,
// stalls the pose output on shifting patterns, and compares every pose word
// against a bit-exact fixed-point predictor kept in a small scoreboard class.
module differential_drive_odometry_tb;

  // One expected pose word.
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] hd;
  } pose_t;

  // Predicts the pose after each accepted word and holds the pending poses.
  class pose_scoreboard;
    logic [31:0]        left_dpc;
    logic [31:0]        right_dpc;
    logic [31:0]        inv_wb;
    bit                 gyro_mode;
    logic signed [15:0] bias;
    logic [15:0]        prev_left;
    logic [15:0]        prev_right;
    logic signed [31:0] x_acc;
    logic signed [31:0] y_acc;
    logic signed [31:0] hd_acc;
    pose_t              pending[$];
    int                 errors;
    longint             atan_tab[24] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288,
      262144, 131072, 65536, 32768, 16384, 8192,
      4096, 2048, 1024, 512, 256, 128};

    function new();
      left_dpc = 0; right_dpc = 0; inv_wb = 0; gyro_mode = 0; bias = 0;
      prev_left = 0; prev_right = 0; x_acc = 0; y_acc = 0; hd_acc = 0;
      errors = 0;
    endfunction

    function logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function void set_reg(ddo_pkg::cfg_reg_t idx, logic [31:0] d);
      case (idx)
        ddo_pkg::REG_LEFT_DPC:  left_dpc = d;
        ddo_pkg::REG_RIGHT_DPC: right_dpc = d;
        ddo_pkg::REG_INV_WB:    inv_wb = d;
        ddo_pkg::REG_DR_MODE:   gyro_mode = d[0];
        ddo_pkg::REG_GYRO_BIAS: bias = d[15:0];
        default: ;
      endcase
    endfunction

    // Advance the pose by one encoder/gyro word and queue the result.
    function void note_input(logic signed [15:0] lc, logic signed [15:0] rc,
                             logic signed [15:0] gz);
      logic [15:0] dlw, drw;
      longint dl, dr, pl, pr, mean, g, diff, dth, r, cx, cy, z, xs, ys;
      bit flip;
      int n;
      pose_t p;
      dlw = lc - prev_left;
      drw = rc - prev_right;
      dl = longint'($signed(dlw));
      dr = longint'($signed(drw));
      pl = dl * longint'(left_dpc);
      pr = dr * longint'(right_dpc);
      mean = (pl + pr) >>> 17;
      if (gyro_mode) begin
        g = longint'(gz) - longint'(bias);
        hd_acc = clamp32(longint'(hd_acc) + g * 65536);
      end else begin
        diff = longint'(clamp32((pr - pl) >>> 16));
        dth = (diff * longint'(inv_wb)) >>> 16;
        hd_acc = clamp32(longint'(hd_acc) + dth);
      end
      // Reduce to (-pi, pi], fold into [-pi/2, pi/2], then rotate.
      r = longint'(hd_acc) % 411774;
      if (r < 0) r += 411774;
      if (r > 205887) r -= 411774;
      flip = 0;
      if (r > 102944) begin
        r -= 205887; flip = 1;
      end else if (r < -102944) begin
        r += 205887; flip = 1;
      end
      z = r * 16384;
      cx = 652032874;
      cy = 0;
      n = (ddo_pkg::CORDIC_STEPS > 24) ? 24 : ddo_pkg::CORDIC_STEPS;
      for (int i = 0; i < n; i++) begin
        xs = cx >>> i;
        ys = cy >>> i;
        if (z >= 0) begin
          cx -= ys; cy += xs; z -= atan_tab[i];
        end else begin
          cx += ys; cy -= xs; z += atan_tab[i];
        end
      end
      if (flip) begin
        cx = -cx; cy = -cy;
      end
      x_acc = clamp32(longint'(x_acc) + ((mean * cx) >>> 30));
      y_acc = clamp32(longint'(y_acc) + ((mean * cy) >>> 30));
      prev_left = lc;
      prev_right = rc;
      p.x = x_acc; p.y = y_acc; p.hd = hd_acc;
      pending.push_back(p);
    endfunction

    function void check_result(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] hd);
      pose_t p;
      if (pending.size() == 0) begin
        $error("pose word with nothing pending: x=%0d y=%0d heading=%0d", x, y, hd);
        errors++;
        return;
      end
      p = pending.pop_front();
      if (x !== p.x) begin
        $error("pos_x expected %0d actual %0d", p.x, x); errors++;
      end
      if (y !== p.y) begin
        $error("pos_y expected %0d actual %0d", p.y, y); errors++;
      end
      if (hd !== p.hd) begin
        $error("heading expected %0d actual %0d", p.hd, hd); errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [15:0] left_count = 0;
  logic signed [15:0] right_count = 0;
  logic signed [15:0] gyro_rate = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [31:0] pos_x, pos_y, heading;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = 0;
  logic [31:0]        cfg_data = 0;

  pose_scoreboard sb = new();
  int burst_left = 0;
  int stall_mode = 0;
  int stall_run = 0;
  int cyc = 0;
  logic signed [15:0] cur_l = 0, cur_r = 0;

  differential_drive_odometry dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .left_count(left_count), .right_count(right_count), .gyro_rate(gyro_rate),
    .out_valid(out_valid), .out_stall(out_stall),
    .pos_x(pos_x), .pos_y(pos_y), .heading(heading),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver: switch periodically between stall patterns (none, coin flip, long runs).
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 1000 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_run == 0) begin
          stall_run <= $urandom_range(1, 80);
          out_stall <= ~out_stall;
        end else begin
          stall_run <= stall_run - 1;
        end
      end
    endcase
  end

  // Check every pose word that moves.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(pos_x, pos_y, heading);
  end

  // Send one word; open a new burst after a random gap when the last one runs out.
  task automatic send_word(logic signed [15:0] lc, logic signed [15:0] rc,
                           logic signed [15:0] gz);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 60);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    left_count <= lc;
    right_count <= rc;
    gyro_rate <= gz;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(lc, rc, gz);
    burst_left--;
    cur_l = lc;
    cur_r = rc;
  endtask

  // Hold valid across back-to-back writes; caller drops it.
  task automatic write_reg(ddo_pkg::cfg_reg_t idx, logic [31:0] d);
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic configure(int ph);
    logic [31:0] ld, rd, iw, md, bs;
    case (ph)
      1: begin
        ld = 32'hFFFFFFFF; rd = 32'hFFFFFFFF; iw = 32'hFFFFFFFF; md = 0; bs = 32'hFFFF8000;
      end
      2: begin
        ld = 32'hFFFFFFFF; rd = 0; iw = 0; md = 1; bs = 32'h00007FFF;
      end
      3: begin
        ld = 0; rd = 32'hFFFFFFFF; iw = 1; md = 32'hFFFFFFFE; bs = 0;
      end
      default: begin
        ld = $urandom_range(0, 1 << 24);
        rd = ($urandom_range(0, 3) == 0) ? ld : $urandom_range(0, 1 << 24);
        iw = $urandom_range(1 << 16, 1 << 20);
        md = $urandom();
        bs = $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 8) - 4;
      end
    endcase
    write_reg(ddo_pkg::REG_LEFT_DPC, ld);
    write_reg(ddo_pkg::REG_RIGHT_DPC, rd);
    write_reg(ddo_pkg::REG_INV_WB, iw);
    write_reg(ddo_pkg::REG_DR_MODE, md);
    write_reg(ddo_pkg::REG_GYRO_BIAS, bs);
    cfg_valid <= 0;
  endtask

  // Fail-safe limit.
  initial begin
    #20000000;
    $display("differential_drive_odometry_tb NOT OK");
    $finish;
  end

  initial begin
    logic signed [15:0] lc, rc, gz;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int ph = 0; ph < 9; ph++) begin
      if (ph > 0) configure(ph);
      // Directed: count extremes, wrap-around deltas, gyro extremes.
      if (ph < 3) begin
        send_word(0, 0, 0);
        send_word(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_word(16'sh8000, 16'sh7FFF, 16'sh8000);
        send_word(16'sh7FFF, 16'sh7FFF, -1);
        send_word(16'sh8000, 16'sh8000, 1);
        send_word(-1, 1, 0);
        send_word(16'sh4000, -16'sh4000, 16'sh5555);
        send_word(16'shC000, 16'sh4000, -16'sh5556);
      end
      for (int k = 0; k < 200; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          lc = 16'($urandom()); rc = 16'($urandom());
        end else begin
          lc = 16'(cur_l + $signed($urandom_range(0, 600)) - 300);
          rc = 16'(cur_r + $signed($urandom_range(0, 600)) - 300);
        end
        gz = 16'(($urandom_range(0, 9) == 0) ? $urandom()
                                              : $signed($urandom_range(0, 8)) - 4);
        send_word(lc, rc, gz);
      end
      in_valid <= 0;
      burst_left = 0;
      drain();
    end
    if (sb.errors == 0) begin
      $display("differential_drive_odometry_tb OK");
    end else begin
      $display("differential_drive_odometry_tb NOT OK");
    end
    $finish;
  end

endmodule
